### hw/rtl/round_robin_ready_queue_top_defines.svh
// Assertion macros shared by the ready queue RTL.
`ifndef ROUND_ROBIN_READY_QUEUE_TOP_DEFINES_SVH
`define ROUND_ROBIN_READY_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// cond must hold at every clock edge out of reset
`define RRQ_CHECK(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rrq check failed");
// cons must hold in the cycle after ante
`define RRQ_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrq check failed");
`else
`define RRQ_CHECK(lbl, cond)
`define RRQ_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/rrq_pkg.sv
package rrq_pkg;

    localparam int MAX_TASKS = 16;
    // task field width is fixed by the item format
    localparam int TASK_W    = 4;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    // link code MAX_TASKS means null
    localparam int LINK_W    = $clog2(MAX_TASKS + 1);

    typedef logic [LINK_W-1:0] link_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam link_t NIL_SLOT = LINK_W'(MAX_TASKS);

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_POP    = 2'd2,
        ACT_TICK   = 2'd3
    } action_t;

    typedef struct packed {
        action_t           action;
        logic [TASK_W-1:0] task_id;
    } item_t;

    typedef struct packed {
        logic [TASK_W-1:0] popped_task;
        logic              popped_valid;
        logic              status;
        logic [TASK_W-1:0] running_task;
        logic              running_valid;
    } result_t;

    function automatic logic is_slot(link_t s);
        return s < NIL_SLOT;
    endfunction

endpackage

### hw/rtl/round_robin_ready_queue_top.sv
// Round-robin ready queue over a doubly linked list of task slots.
// The item is held in the input reg, then its result in the result reg; result back-pressure can stall both.
// Throughput: one item per cycle while result_ready is not held low; the combinational list update sets the pace.
// Reset (rst_n, async low): queue holds idle task 0, which is also current;
// all links null, both pipeline registers empty.
`include "round_robin_ready_queue_top_defines.svh"

module round_robin_ready_queue_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  rrq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output rrq_pkg::result_t result
);

    rrq_pkg::item_t   item_reg;
    logic             item_valid_reg;
    rrq_pkg::result_t result_reg;
    rrq_pkg::result_t core_result;
    logic             result_valid_reg;
    logic             advance;

    // the held item commits to list state only when it moves to the result reg
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    rrq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `RRQ_CHECK_NEXT(a_held_item_kept, item_valid_reg && !advance, item_valid_reg)
    `RRQ_CHECK_NEXT(a_advance_fills_result, advance, result_valid_reg)

endmodule

### hw/rtl/rrq_core.sv
`include "round_robin_ready_queue_top_defines.svh"

module rrq_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  rrq_pkg::item_t   item,
    output rrq_pkg::result_t result
);

    rrq_pkg::link_t nl_reg [rrq_pkg::MAX_TASKS];
    rrq_pkg::link_t nl_next[rrq_pkg::MAX_TASKS];
    rrq_pkg::link_t pl_reg [rrq_pkg::MAX_TASKS];
    rrq_pkg::link_t pl_next[rrq_pkg::MAX_TASKS];
    logic [rrq_pkg::MAX_TASKS-1:0] iq_reg, iq_next;
    rrq_pkg::link_t head_reg, head_next;
    rrq_pkg::link_t tail_reg, tail_next;
    rrq_pkg::link_t cur_reg, cur_next;

    logic           task_ok;
    rrq_pkg::idx_t  t_idx;
    rrq_pkg::link_t t_link;
    rrq_pkg::idx_t  head_idx, tail_idx, cur_idx;
    logic           do_unlink;
    rrq_pkg::idx_t  u_idx;
    rrq_pkg::link_t u_link;
    rrq_pkg::link_t nx, pv;
    rrq_pkg::idx_t  nx_idx, pv_idx;
    rrq_pkg::link_t cur_follow;
    logic           status;
    logic           popped_valid;

    assign task_ok  = (32'(item.task_id) < rrq_pkg::MAX_TASKS);
    assign t_idx    = rrq_pkg::IDX_W'(item.task_id);
    assign t_link   = rrq_pkg::LINK_W'(t_idx);
    assign head_idx = head_reg[rrq_pkg::IDX_W-1:0];
    assign tail_idx = tail_reg[rrq_pkg::IDX_W-1:0];
    assign cur_idx  = cur_reg[rrq_pkg::IDX_W-1:0];
    assign u_link   = rrq_pkg::LINK_W'(u_idx);
    assign nx       = nl_reg[u_idx];
    assign pv       = pl_reg[u_idx];
    assign nx_idx   = nx[rrq_pkg::IDX_W-1:0];
    assign pv_idx   = pv[rrq_pkg::IDX_W-1:0];
    assign cur_follow = nl_reg[cur_idx];

    always_comb
    begin
        nl_next      = nl_reg;
        pl_next      = pl_reg;
        iq_next      = iq_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_next     = cur_reg;
        status       = 1'b0;
        popped_valid = 1'b0;
        do_unlink    = 1'b0;
        u_idx        = t_idx;

        unique case (item.action)
            rrq_pkg::ACT_APPEND:
            begin
                if (!task_ok || iq_reg[t_idx])
                begin
                    status = 1'b1;
                end
                else
                begin
                    nl_next[t_idx] = rrq_pkg::NIL_SLOT;
                    pl_next[t_idx] = rrq_pkg::is_slot(tail_reg) ? tail_reg : rrq_pkg::NIL_SLOT;
                    iq_next[t_idx] = 1'b1;
                    if (!rrq_pkg::is_slot(head_reg))
                    begin
                        head_next = t_link;
                    end
                    else if (rrq_pkg::is_slot(tail_reg))
                    begin
                        nl_next[tail_idx] = t_link;
                    end
                    tail_next = t_link;
                end
            end
            rrq_pkg::ACT_REMOVE:
            begin
                if (!task_ok || !iq_reg[t_idx])
                begin
                    status = 1'b1;
                end
                else
                begin
                    do_unlink = 1'b1;
                end
            end
            rrq_pkg::ACT_POP:
            begin
                if (!rrq_pkg::is_slot(head_reg))
                begin
                    status = 1'b1;
                end
                else
                begin
                    popped_valid = 1'b1;
                    u_idx        = head_idx;
                    do_unlink    = iq_reg[head_idx];
                end
            end
            rrq_pkg::ACT_TICK:
            begin
                if (rrq_pkg::is_slot(cur_reg) && rrq_pkg::is_slot(cur_follow))
                begin
                    cur_next = cur_follow;
                end
                else
                begin
                    cur_next = rrq_pkg::is_slot(head_reg) ? head_reg : rrq_pkg::NIL_SLOT;
                end
            end
            default:
            begin
                status = 1'b0;
            end
        endcase

        // unlink reads only registered state; later writes win as in sequential code
        if (do_unlink)
        begin
            iq_next[u_idx] = 1'b0;
            if (head_reg == u_link)
            begin
                head_next = rrq_pkg::is_slot(nx) ? nx : rrq_pkg::NIL_SLOT;
                if (tail_reg == u_link)
                begin
                    tail_next = rrq_pkg::NIL_SLOT;
                end
                else if (rrq_pkg::is_slot(nx))
                begin
                    pl_next[nx_idx] = rrq_pkg::NIL_SLOT;
                end
            end
            else
            begin
                if (rrq_pkg::is_slot(pv))
                begin
                    nl_next[pv_idx] = rrq_pkg::is_slot(nx) ? nx : rrq_pkg::NIL_SLOT;
                end
                if (tail_reg == u_link)
                begin
                    tail_next = rrq_pkg::is_slot(pv) ? pv : rrq_pkg::NIL_SLOT;
                end
                else if (rrq_pkg::is_slot(nx))
                begin
                    pl_next[nx_idx] = rrq_pkg::is_slot(pv) ? pv : rrq_pkg::NIL_SLOT;
                end
            end
        end
    end

    always_comb
    begin
        result.popped_task   = popped_valid ? rrq_pkg::TASK_W'(head_reg) : '0;
        result.popped_valid  = popped_valid;
        result.status        = status;
        result.running_valid = rrq_pkg::is_slot(cur_next);
        result.running_task  = rrq_pkg::is_slot(cur_next) ? rrq_pkg::TASK_W'(cur_next) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrq_pkg::MAX_TASKS; i++)
            begin
                nl_reg[i] <= rrq_pkg::NIL_SLOT;
                pl_reg[i] <= rrq_pkg::NIL_SLOT;
            end
            iq_reg   <= rrq_pkg::MAX_TASKS'(1);
            head_reg <= '0;
            tail_reg <= '0;
            cur_reg  <= '0;
        end
        else if (step)
        begin
            nl_reg   <= nl_next;
            pl_reg   <= pl_next;
            iq_reg   <= iq_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            cur_reg  <= cur_next;
        end
    end

    `RRQ_CHECK(a_head_tail_null, rrq_pkg::is_slot(head_reg) == rrq_pkg::is_slot(tail_reg))
    `RRQ_CHECK(a_empty_head_null, (iq_reg == '0) == !rrq_pkg::is_slot(head_reg))
    `RRQ_CHECK(a_head_member, !rrq_pkg::is_slot(head_reg) || iq_reg[head_idx])
    `RRQ_CHECK(a_tail_member, !rrq_pkg::is_slot(tail_reg) || iq_reg[tail_idx])

endmodule

### verif/round_robin_ready_queue_top_tb.sv
module round_robin_ready_queue_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 650;
    localparam int CHUNK        = 50;
    localparam int TAIL_CYCLES  = 10;
    localparam int CYCLE_LIMIT  = 200000;

    // Keeps its own copy of the linked list and the expected results in order.
    class ready_queue_scoreboard;
        rrq_pkg::link_t   next_tab [rrq_pkg::MAX_TASKS];
        rrq_pkg::link_t   prev_tab [rrq_pkg::MAX_TASKS];
        bit               member   [rrq_pkg::MAX_TASKS];
        rrq_pkg::link_t   head;
        rrq_pkg::link_t   tail;
        rrq_pkg::link_t   running;
        rrq_pkg::result_t expected_q [$];
        int               errors;

        function new();
            for (int i = 0; i < rrq_pkg::MAX_TASKS; i++)
            begin
                next_tab[i] = rrq_pkg::NIL_SLOT;
                prev_tab[i] = rrq_pkg::NIL_SLOT;
                member[i]   = 1'b0;
            end
            member[0] = 1'b1;
            head      = '0;
            tail      = '0;
            running   = '0;
            errors    = 0;
        endfunction

        function bit is_task(rrq_pkg::link_t s);
            return s < rrq_pkg::NIL_SLOT;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // links of the removed slot stay as they were
        function void unlink(rrq_pkg::link_t t);
            rrq_pkg::link_t nx;
            rrq_pkg::link_t pv;
            nx = next_tab[t];
            pv = prev_tab[t];
            member[t] = 1'b0;
            if (head == t)
            begin
                head = is_task(nx) ? nx : rrq_pkg::NIL_SLOT;
                if (tail == t)
                    tail = rrq_pkg::NIL_SLOT;
                else if (is_task(nx))
                    prev_tab[nx] = rrq_pkg::NIL_SLOT;
            end
            else
            begin
                if (is_task(pv))
                    next_tab[pv] = is_task(nx) ? nx : rrq_pkg::NIL_SLOT;
                if (tail == t)
                    tail = is_task(pv) ? pv : rrq_pkg::NIL_SLOT;
                else if (is_task(nx))
                    prev_tab[nx] = is_task(pv) ? pv : rrq_pkg::NIL_SLOT;
            end
        endfunction

        function void note_item(rrq_pkg::item_t it);
            rrq_pkg::result_t r;
            rrq_pkg::link_t   t;
            r = '0;
            t = rrq_pkg::link_t'(it.task_id);
            case (it.action)
                rrq_pkg::ACT_APPEND:
                begin
                    if (!is_task(t) || member[t])
                        r.status = 1'b1;
                    else
                    begin
                        next_tab[t] = rrq_pkg::NIL_SLOT;
                        prev_tab[t] = is_task(tail) ? tail : rrq_pkg::NIL_SLOT;
                        member[t]   = 1'b1;
                        if (!is_task(head))
                            head = t;
                        else if (is_task(tail))
                            next_tab[tail] = t;
                        tail = t;
                    end
                end
                rrq_pkg::ACT_REMOVE:
                begin
                    if (!is_task(t) || !member[t])
                        r.status = 1'b1;
                    else
                        unlink(t);
                end
                rrq_pkg::ACT_POP:
                begin
                    if (!is_task(head))
                        r.status = 1'b1;
                    else
                    begin
                        r.popped_task  = head[rrq_pkg::TASK_W-1:0];
                        r.popped_valid = 1'b1;
                        if (member[head])
                            unlink(head);
                    end
                end
                rrq_pkg::ACT_TICK:
                begin
                    if (is_task(running) && is_task(next_tab[running]))
                        running = next_tab[running];
                    else
                        running = is_task(head) ? head : rrq_pkg::NIL_SLOT;
                end
            endcase
            if (is_task(running))
            begin
                r.running_task  = running[rrq_pkg::TASK_W-1:0];
                r.running_valid = 1'b1;
            end
            expected_q.push_back(r);
        endfunction

        task compare_field(string name, int got, int exp);
            if (got != exp)
                report($sformatf("%s: got %0d, expected %0d", name, got, exp));
        endtask

        task check_result(rrq_pkg::result_t got);
            rrq_pkg::result_t exp;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %h with no item pending", got));
                return;
            end
            exp = expected_q.pop_front();
            compare_field("popped_task", int'(got.popped_task), int'(exp.popped_task));
            compare_field("popped_valid", int'(got.popped_valid), int'(exp.popped_valid));
            compare_field("status", int'(got.status), int'(exp.status));
            compare_field("running_task", int'(got.running_task), int'(exp.running_task));
            compare_field("running_valid", int'(got.running_valid),
                          int'(exp.running_valid));
        endtask
    endclass

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    rrq_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    rrq_pkg::result_t result;

    ready_queue_scoreboard sb = new();

    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;
    int cycle_count = 0;

    round_robin_ready_queue_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    // valid stays high across back-to-back items; lowered only for a real gap
    task automatic send_item(rrq_pkg::action_t act, logic [rrq_pkg::TASK_W-1:0] id);
        rrq_pkg::item_t it;
        int             gap;
        it.action  = act;
        it.task_id = id;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(it);
    endtask

    task automatic drain_results();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(int append_weight);
        int               r;
        rrq_pkg::action_t act;
        r = $urandom_range(0, 99);
        if (r < append_weight)
            act = rrq_pkg::ACT_APPEND;
        else if (r < append_weight + 20)
            act = rrq_pkg::ACT_REMOVE;
        else if (r < append_weight + 35)
            act = rrq_pkg::ACT_POP;
        else
            act = rrq_pkg::ACT_TICK;
        send_item(act, rrq_pkg::TASK_W'($urandom_range(0, rrq_pkg::MAX_TASKS - 1)));
    endtask

    // result side
    initial
    begin
        int gap;
        @(posedge clk iff rst_n);
        forever
        begin
            gap = draw_gap(recv_burst);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            sb.check_result(result);
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle task handling, empty queue, ignored actions, stale links
        send_item(rrq_pkg::ACT_TICK, 4'd0);
        send_item(rrq_pkg::ACT_APPEND, 4'd0);
        send_item(rrq_pkg::ACT_REMOVE, 4'd5);
        send_item(rrq_pkg::ACT_POP, 4'd0);
        send_item(rrq_pkg::ACT_POP, 4'd15);
        send_item(rrq_pkg::ACT_TICK, 4'd0);
        send_item(rrq_pkg::ACT_TICK, 4'd0);
        send_item(rrq_pkg::ACT_REMOVE, 4'd0);
        send_item(rrq_pkg::ACT_APPEND, 4'd15);
        send_item(rrq_pkg::ACT_TICK, 4'd0);
        send_item(rrq_pkg::ACT_APPEND, 4'd0);
        send_item(rrq_pkg::ACT_APPEND, 4'd7);
        send_item(rrq_pkg::ACT_APPEND, 4'd15);
        send_item(rrq_pkg::ACT_TICK, 4'd0);
        // current removed, next tick follows its old next link
        send_item(rrq_pkg::ACT_REMOVE, 4'd0);
        send_item(rrq_pkg::ACT_TICK, 4'd0);
        send_item(rrq_pkg::ACT_REMOVE, 4'd7);
        send_item(rrq_pkg::ACT_APPEND, 4'd3);
        send_item(rrq_pkg::ACT_REMOVE, 4'd15);
        send_item(rrq_pkg::ACT_TICK, 4'd0);
        send_item(rrq_pkg::ACT_POP, 4'd0);
        send_item(rrq_pkg::ACT_APPEND, 4'd10);
        send_item(rrq_pkg::ACT_TICK, 4'd0);
        send_item(rrq_pkg::ACT_POP, 4'd0);
        send_item(rrq_pkg::ACT_TICK, 4'd0);

        for (int c = 0; c < RANDOM_ITEMS / CHUNK; c++)
        begin
            int weight;
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            weight     = $urandom_range(20, 50);
            if (c % 4 == 2)
            begin
                item_valid <= 1'b0;
                drain_results();
            end
            for (int i = 0; i < CHUNK; i++)
                send_random(weight);
        end

        // drop valid at the accepting edge so the last item is not sent twice
        item_valid <= 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### round_robin_ready_queue_top.f
+incdir+hw/rtl
hw/rtl/rrq_pkg.sv
hw/rtl/rrq_core.sv
hw/rtl/round_robin_ready_queue_top.sv
verif/round_robin_ready_queue_top_tb.sv
